// ----- rtl/bitmap_range_engine_defines.svh -----
// assertion macros shared by the bitmap range engine rtl
// expects signals clk and rst in the scope of each use
`ifndef BITMAP_RANGE_ENGINE_DEFINES_SVH
`define BITMAP_RANGE_ENGINE_DEFINES_SVH

// condition holds at every edge outside reset
`define BRE_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds at the edge after the trigger
`define BRE_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

// consequence holds at the same edge as the trigger
`define BRE_ASSERT_SAME(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

// ----- rtl/bre_pkg.sv -----
// shared types and constants of the bitmap range engine
// no dependencies
package bre_pkg;

  localparam int WORD_BITS_DEF  = 64;
  localparam int WORD_COUNT_DEF = 64;

  localparam int MODE_W   = 3;
  localparam int START_W  = 12;
  localparam int LENGTH_W = 13;
  // range end holds the largest start plus the largest length without wrapping
  localparam int STOP_W   = 14;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 3'd0,
    MODE_CLEAR = 3'd1,
    MODE_FLIP  = 3'd2,
    MODE_CHECK = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  // command token walking the row of cells
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               act;    // command is carried out
    logic [START_W-1:0] start;  // first bit of range
    logic [STOP_W-1:0]  stop;   // one past last bit of range
    logic               val;    // check value
    logic               res;    // running result bit
    logic               err;    // range error
  } tok_t;

endpackage

// ----- rtl/bre_if.sv -----
// valid/ready channel interfaces for command and result words
// depends on bre_pkg
interface bre_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [bre_pkg::MODE_W-1:0]    mode;
  logic [bre_pkg::START_W-1:0]   start_req;
  logic [bre_pkg::LENGTH_W-1:0]  length;
  logic                          check_value;

  modport source (output valid, mode, start_req, length, check_value, input ready);
  modport sink   (input valid, mode, start_req, length, check_value, output ready);
endinterface

interface bre_rsp_if;
  logic valid;
  logic ready;
  logic result_bit;
  logic range_error;

  modport source (output valid, result_bit, range_error, input ready);
  modport sink   (input valid, result_bit, range_error, output ready);
endinterface

// ----- rtl/bre_cell.sv -----
// one cell of the bitmap row: holds one word, applies the passing command to it
// depends on bre_pkg
module bre_cell #(
  parameter int WORD_BITS  = bre_pkg::WORD_BITS_DEF,
  parameter int WORD_COUNT = bre_pkg::WORD_COUNT_DEF,
  parameter int IDX        = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  bre_pkg::tok_t in_tok,
  output logic          out_valid,
  output bre_pkg::tok_t out_tok
);

  localparam int POS_W = $clog2(WORD_BITS * WORD_COUNT + (1 << bre_pkg::STOP_W));
  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam int SH_W  = $clog2(WORD_BITS);
  localparam logic [POS_W-1:0] BASE = POS_W'(IDX * WORD_BITS);
  localparam logic [POS_W-1:0] TOP  = POS_W'((IDX + 1) * WORD_BITS);
  localparam logic [WORD_BITS:0] ONE_EXT = (WORD_BITS + 1)'(1);

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] word_next;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS:0]   ones_ext;
  logic [POS_W-1:0]     lo;
  logic [POS_W-1:0]     hi;
  logic [POS_W-1:0]     span;
  logic [CNT_W-1:0]     n;
  logic [SH_W-1:0]      sh;
  logic                 hit;
  bre_pkg::tok_t        tok_next;

  // overlap of [start, stop) with this word
  always_comb begin
    lo   = (POS_W'(in_tok.start) > BASE) ? POS_W'(in_tok.start) : BASE;
    hi   = (POS_W'(in_tok.stop) < TOP) ? POS_W'(in_tok.stop) : TOP;
    hit  = hi > lo;
    span = hi - lo;
    n    = CNT_W'(span);
    sh   = SH_W'(lo - BASE);
    ones_ext = (ONE_EXT << n) - ONE_EXT;
    mask = hit ? (ones_ext[WORD_BITS-1:0] << sh) : '0;
  end

  always_comb begin
    tok_next  = in_tok;
    word_next = word;
    case (in_tok.mode)
      bre_pkg::MODE_SET:   word_next = word | mask;
      bre_pkg::MODE_CLEAR: word_next = word & ~mask;
      bre_pkg::MODE_FLIP:  word_next = word ^ mask;
      bre_pkg::MODE_CHECK: begin
        if ((word & mask) != ({WORD_BITS{in_tok.val}} & mask)) tok_next.res = 1'b0;
      end
      bre_pkg::MODE_READ: begin
        if (in_tok.act && hit) tok_next.res = |(word & mask);
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
      if (in_valid && in_tok.act) word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    out_tok <= tok_next;
  end

endmodule

// ----- rtl/bitmap_range_engine.sv -----
// bitmap range engine: set, clear, flip, check or read a bit range of a word bitmap
// flow: each accepted command walks the cell row from cell 0 to the last cell, then fills the result word
// one command at a time: a new command word waits until the token has left the last cell
// reset: synchronous rst clears the whole bitmap to zero, drops pending words
// depends on bre_pkg, bre_if, bre_cell and bitmap_range_engine_defines.svh
`include "bitmap_range_engine_defines.svh"

module bitmap_range_engine #(
  parameter int WORD_BITS  = bre_pkg::WORD_BITS_DEF,
  parameter int WORD_COUNT = bre_pkg::WORD_COUNT_DEF
) (
  input logic      clk,
  input logic      rst,
  bre_cmd_if.sink   cmd,
  bre_rsp_if.source rsp
);

  // wide enough for any bit position of the bitmap and any range end
  localparam int POS_W      = $clog2(WORD_BITS * WORD_COUNT + (1 << bre_pkg::STOP_W));
  localparam int TOTAL_BITS = WORD_BITS * WORD_COUNT;

  // tok[i] / tok_valid[i] feed cell i; index WORD_COUNT is the row output
  bre_pkg::tok_t         tok [WORD_COUNT+1];
  logic [WORD_COUNT:0]   tok_valid;
  logic [WORD_COUNT-1:0] chain_valid;

  logic                       busy;
  logic                       out_valid;
  logic                       out_result;
  logic                       out_error;
  logic                       accept;
  logic [bre_pkg::STOP_W-1:0] stop_range;
  logic [bre_pkg::STOP_W-1:0] stop_read;
  logic                       range_bad;
  logic                       read_bad;
  bre_pkg::tok_t              inject;

  // one command in the row at a time; the result slot must be free or draining
  assign cmd.ready = !busy && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  // range end and bounds checks at entry
  always_comb begin
    stop_range = bre_pkg::STOP_W'(cmd.start_req) + bre_pkg::STOP_W'(cmd.length);
    stop_read  = bre_pkg::STOP_W'(cmd.start_req) + bre_pkg::STOP_W'(1);
    range_bad  = POS_W'(stop_range) > POS_W'(TOTAL_BITS);
    read_bad   = POS_W'(cmd.start_req) >= POS_W'(TOTAL_BITS);
  end

  // build the token that enters cell 0
  always_comb begin
    inject.mode  = cmd.mode;
    inject.start = cmd.start_req;
    inject.val   = cmd.check_value;
    inject.stop  = stop_range;
    inject.act   = 1'b0;
    inject.res   = 1'b0;
    inject.err   = 1'b0;
    case (cmd.mode)
      bre_pkg::MODE_SET, bre_pkg::MODE_CLEAR, bre_pkg::MODE_FLIP: begin
        inject.act = !range_bad;
        inject.err = range_bad;
      end
      bre_pkg::MODE_CHECK: begin
        // check starts true and any mismatching word knocks it down
        inject.act = !range_bad;
        inject.err = range_bad;
        inject.res = !range_bad;
      end
      bre_pkg::MODE_READ: begin
        // a read is a one bit range; the word holding it reports the bit
        inject.stop = stop_read;
        inject.act  = !read_bad;
        inject.err  = read_bad;
      end
      default: begin
        // unused modes walk the row with no effect
        inject.act = 1'b0;
      end
    endcase
  end

  assign tok[0]       = inject;
  assign tok_valid[0] = accept;

  // the row of cells, one word each, token handed on every cycle
  for (genvar i = 0; i < WORD_COUNT; i++) begin : g_cell
    bre_cell #(
      .WORD_BITS  (WORD_BITS),
      .WORD_COUNT (WORD_COUNT),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (tok_valid[i]),
      .in_tok    (tok[i]),
      .out_valid (tok_valid[i+1]),
      .out_tok   (tok[i+1])
    );
  end

  assign chain_valid = tok_valid[WORD_COUNT:1];

  // busy from entry until the token leaves the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) busy <= 1'b1;
      else if (tok_valid[WORD_COUNT]) busy <= 1'b0;

      if (tok_valid[WORD_COUNT]) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (tok_valid[WORD_COUNT]) begin
      out_result <= tok[WORD_COUNT].res;
      out_error  <= tok[WORD_COUNT].err;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_bit  = out_result;
  assign rsp.range_error = out_error;

  // at most one token in flight, and busy tracks it exactly
  `BRE_ASSERT_ALWAYS(a_single_token, $onehot0(chain_valid), "more than one token in the row")
  `BRE_ASSERT_ALWAYS(a_busy_tracks, busy == (|chain_valid), "busy out of step with the row")
  // a finishing token never lands on an unread result
  `BRE_ASSERT_SAME(a_slot_free, tok_valid[WORD_COUNT], !out_valid, "result slot overrun")
  // an accepted command is in cell 0 at the next edge
  `BRE_ASSERT_NEXT(a_enter_row, accept, chain_valid[0] && busy, "accepted word not in row")

endmodule
